// ----- design/npc_pkg.sv -----
// Shared types, palette table and helper functions for the nearest palette color block.
package npc_pkg;

	localparam int SLOTS  = 16;
	localparam int IDX_W  = $clog2(SLOTS);
	localparam int DIST_W = 10;
	localparam int KEY_W  = DIST_W + 1;
	localparam int GRP_W  = 2;
	localparam int MASK_W = 4;

	localparam logic [MASK_W-1:0] MASK_RESET = 4'hF;

	localparam logic [GRP_W-1:0] GRP_FROST  = 2'd0;
	localparam logic [GRP_W-1:0] GRP_POLAR  = 2'd1;
	localparam logic [GRP_W-1:0] GRP_SNOW   = 2'd2;
	localparam logic [GRP_W-1:0] GRP_AURORA = 2'd3;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	// distances of one pixel to every table color, with the mask in force
	typedef struct packed {
		logic [MASK_W-1:0]            mask;
		logic [SLOTS-1:0][DIST_W-1:0] l1;
	} npc_item_t;

	// key is {disabled, distance}; a disabled entry loses to every enabled one
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [IDX_W-1:0] idx;
	} npc_cand_t;

	function automatic rgb_t pal_color(input logic [IDX_W-1:0] idx);
		rgb_t c;
		case (idx)
			4'd0:    c = '{8'd143, 8'd188, 8'd187};
			4'd1:    c = '{8'd136, 8'd192, 8'd208};
			4'd2:    c = '{8'd129, 8'd161, 8'd193};
			4'd3:    c = '{8'd94,  8'd129, 8'd172};
			4'd4:    c = '{8'd46,  8'd52,  8'd64};
			4'd5:    c = '{8'd59,  8'd66,  8'd82};
			4'd6:    c = '{8'd67,  8'd76,  8'd94};
			4'd7:    c = '{8'd76,  8'd86,  8'd106};
			4'd8:    c = '{8'd216, 8'd222, 8'd233};
			4'd9:    c = '{8'd229, 8'd233, 8'd240};
			4'd10:   c = '{8'd236, 8'd239, 8'd244};
			4'd11:   c = '{8'd191, 8'd97,  8'd106};
			4'd12:   c = '{8'd208, 8'd135, 8'd112};
			4'd13:   c = '{8'd235, 8'd203, 8'd139};
			4'd14:   c = '{8'd163, 8'd190, 8'd140};
			default: c = '{8'd180, 8'd142, 8'd173};
		endcase
		return c;
	endfunction

	function automatic logic [GRP_W-1:0] group_of(input logic [IDX_W-1:0] idx);
		logic [GRP_W-1:0] g;
		if (idx < 4'd4)
			g = GRP_FROST;
		else if (idx < 4'd8)
			g = GRP_POLAR;
		else if (idx < 4'd11)
			g = GRP_SNOW;
		else
			g = GRP_AURORA;
		return g;
	endfunction

	function automatic logic [IDX_W-1:0] group_first(input logic [GRP_W-1:0] grp);
		logic [IDX_W-1:0] f;
		case (grp)
			GRP_FROST:  f = 4'd0;
			GRP_POLAR:  f = 4'd4;
			GRP_SNOW:   f = 4'd8;
			default:    f = 4'd11;
		endcase
		return f;
	endfunction

	function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	// keep the earlier candidate on a tie
	function automatic npc_cand_t pick(input npc_cand_t a, input npc_cand_t b);
		return (b.key < a.key) ? b : a;
	endfunction

endpackage

// ----- design/npc_front.sv -----
// Front end: accepts pixels and registers their L1 distances to all table colors.
module npc_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                pixel_red,
	input  logic [7:0]                pixel_green,
	input  logic [7:0]                pixel_blue,
	input  logic [npc_pkg::MASK_W-1:0] mask,
	output logic                      item_valid,
	input  logic                      item_ready,
	output npc_pkg::npc_item_t        item
);
	import npc_pkg::*;

	logic      valid_s1;
	npc_item_t item_s1;
	npc_item_t item_d;
	logic      load;

	always_comb begin
		rgb_t c;
		item_d.mask = mask;
		for (int i = 0; i < SLOTS; i++) begin
			c = pal_color(IDX_W'(i));
			item_d.l1[i] = DIST_W'(abs_diff(pixel_red, c.r))
				+ DIST_W'(abs_diff(pixel_green, c.g))
				+ DIST_W'(abs_diff(pixel_blue, c.b));
		end
	end

	assign load       = !valid_s1 || item_ready;
	assign in_ready   = load;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			item_s1 <= item_d;
		end
	end

endmodule

// ----- design/npc_fifo.sv -----
// Two-entry queue that decouples the distance front end from the selection back end.
module npc_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  npc_pkg::npc_item_t push_data,
	output logic               pop_valid,
	input  logic               pop_ready,
	output npc_pkg::npc_item_t pop_data
);
	import npc_pkg::*;

	npc_item_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- design/npc_back.sv -----
// Back end: registered minimum tree over the distances, slot packing and color lookup.
module npc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  npc_pkg::npc_item_t item,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_red,
	output logic [7:0]         out_green,
	output logic [7:0]         out_blue,
	output logic [3:0]         color_slot
);
	import npc_pkg::*;

	logic                 advance;
	npc_cand_t            quad_d [4];
	npc_cand_t            quad_s1 [4];
	logic [MASK_W-1:0]    mask_s1;
	logic                 valid_s1;
	logic                 out_valid_q;
	rgb_t                 color_d;
	rgb_t                 color_q;
	logic [IDX_W-1:0]     slot_d;
	logic [IDX_W-1:0]     slot_q;

	// hold the whole back end while a result waits at the output
	assign advance    = !out_valid_q || out_ready;
	assign item_ready = advance;

	always_comb begin
		npc_cand_t c [SLOTS];
		npc_cand_t m0;
		npc_cand_t m1;
		for (int i = 0; i < SLOTS; i++) begin
			c[i].key = {!item.mask[group_of(IDX_W'(i))], item.l1[i]};
			c[i].idx = IDX_W'(i);
		end
		for (int q = 0; q < 4; q++) begin
			m0 = pick(c[4*q], c[4*q+1]);
			m1 = pick(c[4*q+2], c[4*q+3]);
			quad_d[q] = pick(m0, m1);
		end
	end

	always_comb begin
		npc_cand_t        w;
		logic [GRP_W-1:0] grp;
		logic [IDX_W:0]   base;
		w    = pick(pick(quad_s1[0], quad_s1[1]), pick(quad_s1[2], quad_s1[3]));
		grp  = group_of(w.idx);
		base = '0;
		// count the enabled entries of the groups packed ahead of the winner
		if (grp > GRP_FROST && mask_s1[GRP_FROST])
			base = base + (IDX_W+1)'(group_first(GRP_POLAR) - group_first(GRP_FROST));
		if (grp > GRP_POLAR && mask_s1[GRP_POLAR])
			base = base + (IDX_W+1)'(group_first(GRP_SNOW) - group_first(GRP_POLAR));
		if (grp > GRP_SNOW && mask_s1[GRP_SNOW])
			base = base + (IDX_W+1)'(group_first(GRP_AURORA) - group_first(GRP_SNOW));
		if (mask_s1 == '0) begin
			color_d = '0;
			slot_d  = '0;
		end else begin
			color_d = pal_color(w.idx);
			slot_d  = IDX_W'(base + (IDX_W+1)'(w.idx - group_first(grp)));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= item_valid;
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			quad_s1 <= quad_d;
			mask_s1 <= item.mask;
			color_q <= color_d;
			slot_q  <= slot_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_red    = color_q.r;
	assign out_green  = color_q.g;
	assign out_blue   = color_q.b;
	assign color_slot = slot_q;

endmodule

// ----- design/nearest_palette_color_l1.sv -----
// Throughput: one pixel per cycle while out_ready holds, set by the 16 parallel
// distance units and the two-level registered minimum tree; a two-entry queue
// separates the front and back ends.
// Reset: arst_n clears the pipeline and queue and sets mask_q to all groups on.
// Top level of the nearest palette color block (Manhattan distance).
module nearest_palette_color_l1 (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [3:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] pixel_red,
	input  logic [7:0] pixel_green,
	input  logic [7:0] pixel_blue,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_red,
	output logic [7:0] out_green,
	output logic [7:0] out_blue,
	output logic [3:0] color_slot
);
	import npc_pkg::*;

	logic [MASK_W-1:0] mask_q;
	logic              f_valid;
	logic              f_ready;
	npc_item_t         f_item;
	logic              b_valid;
	logic              b_ready;
	npc_item_t         b_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= MASK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			mask_q <= cfg_data;
		end
	end

	npc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pixel_red   (pixel_red),
		.pixel_green (pixel_green),
		.pixel_blue  (pixel_blue),
		.mask        (mask_q),
		.item_valid  (f_valid),
		.item_ready  (f_ready),
		.item        (f_item)
	);

	npc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_item),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_item)
	);

	npc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (b_valid),
		.item_ready (b_ready),
		.item       (b_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_red    (out_red),
		.out_green  (out_green),
		.out_blue   (out_blue),
		.color_slot (color_slot)
	);

endmodule

// ----- design/npc_checker.sv -----
// Port-level checker for the nearest palette color block, bound to the top level.
module npc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_red,
	input logic [7:0] out_green,
	input logic [7:0] out_blue,
	input logic [3:0] color_slot
);

	// hold a stalled result transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped before the transaction completed");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_red) && $stable(out_green)
			&& $stable(out_blue) && $stable(color_slot))
		else $error("result changed while stalled");

	// black only comes from an empty palette, which always reports slot zero
	a_black_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0
			|-> color_slot == 4'd0)
		else $error("black result with nonzero slot");

	// first polar night color packs either first or right after the frost group
	a_polar_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_red == 8'd46 && out_green == 8'd52 && out_blue == 8'd64
			|-> color_slot == 4'd0 || color_slot == 4'd4)
		else $error("wrong packed slot for first polar night color");

endmodule

bind nearest_palette_color_l1 npc_checker u_npc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.out_red    (out_red),
	.out_green  (out_green),
	.out_blue   (out_blue),
	.color_slot (color_slot)
);

// ----- dv/nearest_palette_color_l1_test.sv -----
// Self-checking testbench for nearest_palette_color_l1: directed and random pixels under a sweep of group masks.
module nearest_palette_color_l1_test;

	typedef npc_pkg::rgb_t rgb_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [3:0] slot;
	} swatch_t;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int DRAIN_CYCLES  = 12;
	localparam int LONG_HOLD     = 64;
	localparam int PHASE_PIXELS  = 37;
	localparam int PLAN_LEN      = 17;

	// fixed color table, groups packed frost, polar night, snow storm, aurora
	localparam rgb_t SWATCHES [16] = '{
		'{8'd143, 8'd188, 8'd187}, '{8'd136, 8'd192, 8'd208},
		'{8'd129, 8'd161, 8'd193}, '{8'd94,  8'd129, 8'd172},
		'{8'd46,  8'd52,  8'd64},  '{8'd59,  8'd66,  8'd82},
		'{8'd67,  8'd76,  8'd94},  '{8'd76,  8'd86,  8'd106},
		'{8'd216, 8'd222, 8'd233}, '{8'd229, 8'd233, 8'd240},
		'{8'd236, 8'd239, 8'd244}, '{8'd191, 8'd97,  8'd106},
		'{8'd208, 8'd135, 8'd112}, '{8'd235, 8'd203, 8'd139},
		'{8'd163, 8'd190, 8'd140}, '{8'd180, 8'd142, 8'd173}
	};
	localparam int GROUP_BASE [4] = '{0, 4, 8, 11};
	localparam int GROUP_LEN  [4] = '{4, 4, 3, 5};

	localparam logic [npc_pkg::MASK_W-1:0] MASK_PLAN [PLAN_LEN] = '{
		4'hF, 4'h0, 4'h1, 4'h2, 4'h4, 4'h8, 4'h3, 4'h5, 4'h6,
		4'h9, 4'hA, 4'hC, 4'h7, 4'hB, 4'hD, 4'hE, 4'hF
	};

	logic                      clk         = 1'b0;
	logic                      arst_n      = 1'b0;
	logic                      cfg_valid   = 1'b0;
	logic                      cfg_ready;
	logic [npc_pkg::MASK_W-1:0] cfg_data   = '0;
	logic                      in_valid    = 1'b0;
	logic                      in_ready;
	logic [7:0]                pixel_red   = '0;
	logic [7:0]                pixel_green = '0;
	logic [7:0]                pixel_blue  = '0;
	logic                      out_valid;
	logic                      out_ready   = 1'b0;
	logic [7:0]                out_red;
	logic [7:0]                out_green;
	logic [7:0]                out_blue;
	logic [3:0]                color_slot;

	nearest_palette_color_l1 dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pixel_red   (pixel_red),
		.pixel_green (pixel_green),
		.pixel_blue  (pixel_blue),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_red     (out_red),
		.out_green   (out_green),
		.out_blue    (out_blue),
		.color_slot  (color_slot)
	);

	always #10 clk = ~clk;

	rgb_t    pending_pixels [$];
	swatch_t expected_colors [$];

	logic [npc_pkg::MASK_W-1:0] palette_mask = npc_pkg::MASK_RESET;
	bit      calm           = 1'b0;
	bit      long_hold_done = 1'b0;
	int      failures       = 0;
	int      pixels_sent    = 0;
	int      results_seen   = 0;
	int      tie_hits       = 0;
	int      send_gap       = 0;
	int      hold_left      = 0;
	int      cycles         = 0;
	rgb_t    sent_pixel;
	swatch_t sent_hit;
	bit      sent_tied;
	swatch_t want;

	// closest enabled color by L1 distance; earliest packed entry wins a tie
	function automatic swatch_t nearest_swatch(input rgb_t px, input logic [3:0] mask,
			output bit tied);
		swatch_t hit;
		int best;
		int slot;
		int d;
		rgb_t c;
		hit  = '0;
		best = 1 << 20;
		slot = 0;
		tied = 1'b0;
		for (int grp = 0; grp < 4; grp++) begin
			if (mask[grp]) begin
				for (int k = 0; k < GROUP_LEN[grp]; k++) begin
					c = SWATCHES[GROUP_BASE[grp] + k];
					d = (px.r > c.r ? int'(px.r) - int'(c.r) : int'(c.r) - int'(px.r))
					  + (px.g > c.g ? int'(px.g) - int'(c.g) : int'(c.g) - int'(px.g))
					  + (px.b > c.b ? int'(px.b) - int'(c.b) : int'(c.b) - int'(px.b));
					if (d < best) begin
						best = d;
						tied = 1'b0;
						hit  = '{c.r, c.g, c.b, slot[3:0]};
					end else if (d == best) begin
						tied = 1'b1;
					end
					slot++;
				end
			end
		end
		return hit;
	endfunction

	function automatic logic [7:0] nudge(input logic [7:0] c);
		int v;
		v = int'(c) + int'($urandom_range(0, 24)) - 12;
		if (v < 0)
			v = 0;
		else if (v > 255)
			v = 255;
		return v[7:0];
	endfunction

	// half the pixels lie close to some palette color, where choices are tight
	function automatic rgb_t random_pixel();
		rgb_t px;
		rgb_t c;
		int mode;
		mode = $urandom_range(0, 9);
		if (mode < 4) begin
			px = '{8'($urandom), 8'($urandom), 8'($urandom)};
		end else if (mode < 9) begin
			c  = SWATCHES[$urandom_range(0, 15)];
			px = '{nudge(c.r), nudge(c.g), nudge(c.b)};
		end else begin
			px = '{($urandom_range(0, 1) ? 8'd255 : 8'd0), 8'($urandom),
				($urandom_range(0, 1) ? 8'd255 : 8'd0)};
		end
		return px;
	endfunction

	function automatic void check_field(input string name, input int expected, input int actual);
		if (expected != actual) begin
			$error("%s: expected %0d, got %0d", name, expected, actual);
			failures++;
		end
	endfunction

	// driver: present queued pixels, predict each one as it is accepted
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				sent_hit = nearest_swatch(sent_pixel, palette_mask, sent_tied);
				expected_colors.push_back(sent_hit);
				pixels_sent++;
				if (sent_tied)
					tie_hits++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_pixels.size() != 0) begin
					sent_pixel = pending_pixels.pop_front();
					pixel_red   <= sent_pixel.r;
					pixel_green <= sent_pixel.g;
					pixel_blue  <= sent_pixel.b;
					in_valid    <= 1'b1;
					if (!calm && $urandom_range(0, 11) == 0)
						send_gap = $urandom_range(1, 8);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each result transaction, and throttle out_ready
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_colors.size() == 0) begin
					$error("unexpected result: %0d %0d %0d slot %0d",
						out_red, out_green, out_blue, color_slot);
					failures++;
				end else begin
					want = expected_colors.pop_front();
					check_field("out_red", int'(want.r), int'(out_red));
					check_field("out_green", int'(want.g), int'(out_green));
					check_field("out_blue", int'(want.b), int'(out_blue));
					check_field("color_slot", int'(want.slot), int'(color_slot));
					results_seen++;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
			end else if (!long_hold_done && results_seen > 100
					&& pending_pixels.size() >= 20) begin
				// hold off long enough for the block to back up into its input
				hold_left      = LONG_HOLD;
				long_hold_done = 1'b1;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				hold_left = $urandom_range(1, 8);
			end
			out_ready <= (hold_left == 0);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("nearest_palette_color_l1: mismatch");
			$finish;
		end
	end

	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_pixels.size() != 0 || in_valid || expected_colors.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_mask(input logic [npc_pkg::MASK_W-1:0] m);
		cfg_data  <= m;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid    <= 1'b0;
		palette_mask = m;
	endtask

	initial begin
		rgb_t    px;
		bit      tied;
		int      ties_found;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset mask: five corners of the cube, every table color, and ties
		pending_pixels.push_back('{8'd0, 8'd0, 8'd0});
		pending_pixels.push_back('{8'd255, 8'd255, 8'd255});
		pending_pixels.push_back('{8'd255, 8'd0, 8'd0});
		pending_pixels.push_back('{8'd0, 8'd255, 8'd0});
		pending_pixels.push_back('{8'd0, 8'd0, 8'd255});
		for (int i = 0; i < 16; i++)
			pending_pixels.push_back(SWATCHES[i]);
		ties_found = 0;
		for (int n = 0; n < 50000 && ties_found < 3; n++) begin
			px = random_pixel();
			void'(nearest_swatch(px, npc_pkg::MASK_RESET, tied));
			if (tied) begin
				pending_pixels.push_back(px);
				ties_found++;
			end
		end

		// empty palette gives black at slot zero
		wait_drained();
		write_mask(4'h0);
		pending_pixels.push_back('{8'd0, 8'd0, 8'd0});
		pending_pixels.push_back('{8'd255, 8'd255, 8'd255});

		for (int p = 0; p < PLAN_LEN; p++) begin
			wait_drained();
			write_mask(MASK_PLAN[p]);
			if (p == PLAN_LEN - 1)
				calm = 1'b1;
			for (int i = 0; i < PHASE_PIXELS; i++)
				pending_pixels.push_back(random_pixel());
		end

		wait_drained();
		if (expected_colors.size() != 0) begin
			$error("%0d results never arrived", expected_colors.size());
			failures++;
		end
		$display("covered %0d pixels under %0d palette masks, empty palette included,",
			pixels_sent, PLAN_LEN + 2);
		$display("with %0d tied distances and a %0d-cycle output stall", tie_hits, LONG_HOLD);
		if (failures == 0)
			$display("nearest_palette_color_l1: match");
		else
			$display("nearest_palette_color_l1: mismatch");
		$finish;
	end

endmodule
